FILE: hdl/suq_pkg.sv
// Shared types for the sorted unique priority queue.
`default_nettype none
package suq_pkg;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_RNG = 2'd2,
		OP_CLR = 2'd3
	} op_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic enq;
		logic deq;
		logic rng;
	} cell_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/suq_cell.sv
// One cell of the sorted chain: holds one entry, shifts with its neighbors.
`default_nettype none
module suq_cell #(
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 32
) (
	input  wire                         clk,
	input  suq_pkg::cell_cmd_t          cmd,
	input  wire                         live,
	input  wire                         left_gt,
	input  wire  [PRIORITY_BITS-1:0]    new_prio,
	input  wire  [PAYLOAD_BITS-1:0]     new_pay,
	input  wire  [PRIORITY_BITS-1:0]    range_lo,
	input  wire  [PRIORITY_BITS-1:0]    range_hi,
	input  wire  [PRIORITY_BITS-1:0]    left_prio,
	input  wire  [PAYLOAD_BITS-1:0]     left_pay,
	input  wire  [PRIORITY_BITS-1:0]    right_prio,
	input  wire  [PAYLOAD_BITS-1:0]     right_pay,
	output logic [PRIORITY_BITS-1:0]    slot_prio,
	output logic [PAYLOAD_BITS-1:0]     slot_pay,
	output logic                        gt,
	output logic                        eq,
	output logic                        hit
);
	import suq_pkg::*;

	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;
	logic                     keep_rng;

	assign slot_prio = prio_q;
	assign slot_pay  = pay_q;
	assign gt        = live && (prio_q > new_prio);
	assign eq        = live && (prio_q == new_prio);
	assign hit       = live && (prio_q >= range_lo) && (prio_q <= range_hi);
	assign keep_rng  = live && (prio_q > range_hi);

	always_ff @(posedge clk) begin
		priority if (cmd.enq && !gt) begin
			if (left_gt) begin
				prio_q <= new_prio;
				pay_q  <= new_pay;
			end else begin
				prio_q <= left_prio;
				pay_q  <= left_pay;
			end
		end else if (cmd.deq || (cmd.rng && !keep_rng)) begin
			prio_q <= right_prio;
			pay_q  <= right_pay;
		end else begin
			prio_q <= prio_q;
			pay_q  <= pay_q;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sorted_unique_priority_queue.sv
// Top level: sorted unique priority queue built as a chain of entry cells.
// Flow: a request is registered on acceptance, executed in S_EXEC, then loaded into
//   the result registers once the output side is free (pend_q holds it until then).
// A new request is taken only in S_IDLE; a range removal stays in S_EXEC and shifts
//   the chain one place per cycle while a hit remains. Output register frees the input side.
// Reset: queue empty, no result pending; cell storage is not reset.
`default_nettype none
module sorted_unique_priority_queue #(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 32,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire  [1:0]                operation,
	input  wire  [PRIORITY_BITS-1:0]  item_priority,
	input  wire  [PAYLOAD_BITS-1:0]   item_payload,
	input  wire  [PRIORITY_BITS-1:0]  range_low,
	input  wire  [PRIORITY_BITS-1:0]  range_high,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic                      accepted,
	output logic                      popped_valid,
	output logic [PAYLOAD_BITS-1:0]   popped_payload,
	output logic [CW-1:0]             removed_count,
	output logic [CW-1:0]             entry_count,
	output logic                      queue_empty,
	output logic [PRIORITY_BITS-1:0]  top_priority,
	output logic [PAYLOAD_BITS-1:0]   top_payload
);
	import suq_pkg::*;

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                    state_q;
	op_t                       op_q;
	logic [PRIORITY_BITS-1:0]  prio_q, lo_q, hi_q;
	logic [PAYLOAD_BITS-1:0]   pay_q;
	logic [CW-1:0]             occ_q, rem_q;
	logic                      acc_q, pvalid_q, pend_q;
	logic [PAYLOAD_BITS-1:0]   ppay_q;

	logic                      out_valid_q, res_acc_q, res_pvalid_q, res_empty_q;
	logic [PAYLOAD_BITS-1:0]   res_ppay_q, res_tpay_q;
	logic [CW-1:0]             res_rem_q, res_occ_q;
	logic [PRIORITY_BITS-1:0]  res_tprio_q;

	cell_cmd_t                 cmd;
	logic [CAPACITY-1:0]       live, gt, eq, hit;
	logic [PRIORITY_BITS-1:0]  cell_prio [CAPACITY];
	logic [PAYLOAD_BITS-1:0]   cell_pay  [CAPACITY];
	logic                      any_hit, dup, enq_ok, out_free, accept, load_out;

	assign any_hit  = |hit;
	assign dup      = |eq;
	assign enq_ok   = (prio_q != '0) && !dup && (occ_q != CW'(CAPACITY));
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && (!pend_q || out_free);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == S_IDLE) && pend_q && out_free;

	always_comb begin
		cmd = '0;
		if (state_q == S_EXEC) begin
			unique case (op_q)
				OP_ENQ: cmd.enq = enq_ok;
				OP_DEQ: cmd.deq = (occ_q != '0);
				OP_RNG: cmd.rng = any_hit;
				OP_CLR: cmd = '0;
				default: cmd = '0;
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign live[i] = CW'(i) < occ_q;
		suq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.live      (live[i]),
			.left_gt   ((i == 0) ? 1'b1 : gt[(i == 0) ? 0 : i - 1]),
			.new_prio  (prio_q),
			.new_pay   (pay_q),
			.range_lo  (lo_q),
			.range_hi  (hi_q),
			.left_prio (cell_prio[(i == 0) ? 0 : i - 1]),
			.left_pay  (cell_pay[(i == 0) ? 0 : i - 1]),
			.right_prio(cell_prio[(i == CAPACITY - 1) ? i : i + 1]),
			.right_pay (cell_pay[(i == CAPACITY - 1) ? i : i + 1]),
			.slot_prio (cell_prio[i]),
			.slot_pay  (cell_pay[i]),
			.gt        (gt[i]),
			.eq        (eq[i]),
			.hit       (hit[i])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(operation);
			prio_q <= item_priority;
			pay_q  <= item_payload;
			lo_q   <= range_low;
			hi_q   <= range_high;
		end
		if (load_out) begin
			res_acc_q    <= acc_q;
			res_pvalid_q <= pvalid_q;
			res_ppay_q   <= ppay_q;
			res_rem_q    <= rem_q;
			res_occ_q    <= occ_q;
			res_empty_q  <= (occ_q == '0);
			res_tprio_q  <= (occ_q == '0) ? '0 : cell_prio[0];
			res_tpay_q   <= (occ_q == '0) ? '0 : cell_pay[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			rem_q       <= '0;
			acc_q       <= 1'b0;
			pvalid_q    <= 1'b0;
			ppay_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load_out) begin
						pend_q <= 1'b0;
					end
					if (accept) begin
						state_q  <= S_EXEC;
						rem_q    <= '0;
						acc_q    <= 1'b0;
						pvalid_q <= 1'b0;
						ppay_q   <= '0;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						OP_ENQ: begin
							acc_q   <= enq_ok;
							if (enq_ok) begin
								occ_q <= occ_q + 1'b1;
							end
							state_q <= S_IDLE;
							pend_q  <= 1'b1;
						end
						OP_DEQ: begin
							if (occ_q != '0) begin
								occ_q    <= occ_q - 1'b1;
								pvalid_q <= 1'b1;
								ppay_q   <= cell_pay[0];
							end
							state_q <= S_IDLE;
							pend_q  <= 1'b1;
						end
						OP_RNG: begin
							if (any_hit) begin
								occ_q <= occ_q - 1'b1;
								rem_q <= rem_q + 1'b1;
							end else begin
								state_q <= S_IDLE;
								pend_q  <= 1'b1;
							end
						end
						OP_CLR: begin
							rem_q   <= occ_q;
							occ_q   <= '0;
							state_q <= S_IDLE;
							pend_q  <= 1'b1;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = res_acc_q;
	assign popped_valid   = res_pvalid_q;
	assign popped_payload = res_ppay_q;
	assign removed_count  = res_rem_q;
	assign entry_count    = res_occ_q;
	assign queue_empty    = res_empty_q;
	assign top_priority   = res_tprio_q;
	assign top_payload    = res_tpay_q;

endmodule
`default_nettype wire

FILE: hdl/suq_checker.sv
// Port-level checks for the sorted unique priority queue, bound to the top level.
`default_nettype none
module suq_checker #(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 32,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      out_valid,
	input wire                      out_ready,
	input wire                      accepted,
	input wire                      popped_valid,
	input wire [CW-1:0]             removed_count,
	input wire [CW-1:0]             entry_count,
	input wire                      queue_empty,
	input wire [PRIORITY_BITS-1:0]  top_priority,
	input wire [PAYLOAD_BITS-1:0]   top_payload
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped before taken");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (queue_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && queue_empty |-> (top_priority == '0) && (top_payload == '0))
		else $error("empty queue shows a top entry");

	a_nonempty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !queue_empty |-> (top_priority != '0))
		else $error("held top entry has zero priority");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> !popped_valid && (removed_count == '0))
		else $error("enqueue result carries dequeue or removal fields");

endmodule

bind sorted_unique_priority_queue suq_checker #(
	.CAPACITY     (CAPACITY),
	.PRIORITY_BITS(PRIORITY_BITS),
	.PAYLOAD_BITS (PAYLOAD_BITS)
) u_suq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.accepted     (accepted),
	.popped_valid (popped_valid),
	.removed_count(removed_count),
	.entry_count  (entry_count),
	.queue_empty  (queue_empty),
	.top_priority (top_priority),
	.top_payload  (top_payload)
);
`default_nettype wire

FILE: dv/sorted_unique_priority_queue_tb.sv
// Testbench for the sorted unique priority queue: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module sorted_unique_priority_queue_tb;
	import suq_pkg::*;

	localparam int CAP         = 16;
	localparam int PRIO_W      = 16;
	localparam int PAY_W       = 32;
	localparam int CNT_W       = 5;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_SIZE   = 60;

	typedef struct packed {
		op_t               op;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
		logic [PRIO_W-1:0] lo;
		logic [PRIO_W-1:0] hi;
	} request_t;

	typedef struct packed {
		logic              accepted;
		logic              popped_valid;
		logic [PAY_W-1:0]  popped_payload;
		logic [CNT_W-1:0]  removed_count;
		logic [CNT_W-1:0]  entry_count;
		logic              queue_empty;
		logic [PRIO_W-1:0] top_priority;
		logic [PAY_W-1:0]  top_payload;
	} result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic [PRIO_W-1:0] item_priority = '0;
	logic [PAY_W-1:0] item_payload = '0;
	logic [PRIO_W-1:0] range_low = '0;
	logic [PRIO_W-1:0] range_high = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic accepted;
	logic popped_valid;
	logic [PAY_W-1:0] popped_payload;
	logic [CNT_W-1:0] removed_count;
	logic [CNT_W-1:0] entry_count;
	logic queue_empty;
	logic [PRIO_W-1:0] top_priority;
	logic [PAY_W-1:0] top_payload;

	sorted_unique_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.item_priority(item_priority),
		.item_payload(item_payload),
		.range_low(range_low),
		.range_high(range_high),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.popped_valid(popped_valid),
		.popped_payload(popped_payload),
		.removed_count(removed_count),
		.entry_count(entry_count),
		.queue_empty(queue_empty),
		.top_priority(top_priority),
		.top_payload(top_payload)
	);

	request_t pending_requests[$];
	result_t expected_results[$];
	int recent_prios[$];

	// predictor copy of the queue, ascending priority
	logic [PRIO_W-1:0] model_prio[CAP];
	logic [PAY_W-1:0] model_pay[CAP];
	int model_count = 0;

	int mismatches = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int inserts_stored = 0;
	int inserts_refused = 0;
	int full_refusals = 0;
	int pops_done = 0;
	int entries_dropped = 0;
	int gap_left;
	int stall_left;
	int hold_left;
	bit hold_done;
	int idle_cycles;
	request_t drv_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic result_t apply_request(request_t r);
		result_t res;
		int pos;
		int k;
		int keep;
		res = '0;
		case (r.op)
			OP_ENQ: begin
				pos = 0;
				if (r.prio != 0 && model_count < CAP) begin
					while (pos < model_count && model_prio[pos] < r.prio)
						pos++;
					if (!(pos < model_count && model_prio[pos] == r.prio)) begin
						for (k = model_count; k > pos; k--) begin
							model_prio[k] = model_prio[k-1];
							model_pay[k] = model_pay[k-1];
						end
						model_prio[pos] = r.prio;
						model_pay[pos] = r.pay;
						model_count++;
						res.accepted = 1'b1;
					end
				end else if (r.prio != 0) begin
					full_refusals++;
				end
				if (res.accepted)
					inserts_stored++;
				else
					inserts_refused++;
			end
			OP_DEQ: begin
				if (model_count > 0) begin
					model_count--;
					res.popped_valid = 1'b1;
					res.popped_payload = model_pay[model_count];
					pops_done++;
				end
			end
			OP_RNG: begin
				if (r.lo <= r.hi) begin
					keep = 0;
					for (k = 0; k < model_count; k++) begin
						if (!(model_prio[k] >= r.lo && model_prio[k] <= r.hi)) begin
							model_prio[keep] = model_prio[k];
							model_pay[keep] = model_pay[k];
							keep++;
						end
					end
					res.removed_count = CNT_W'(model_count - keep);
					model_count = keep;
				end
			end
			OP_CLR: begin
				res.removed_count = CNT_W'(model_count);
				model_count = 0;
			end
		endcase
		entries_dropped += res.removed_count;
		res.entry_count = CNT_W'(model_count);
		res.queue_empty = (model_count == 0);
		if (model_count > 0) begin
			res.top_priority = model_prio[model_count-1];
			res.top_payload = model_pay[model_count-1];
		end
		return res;
	endfunction

	task automatic add_request(op_t op, logic [PRIO_W-1:0] prio, logic [PAY_W-1:0] pay,
			logic [PRIO_W-1:0] lo, logic [PRIO_W-1:0] hi);
		request_t r;
		r.op = op;
		r.prio = prio;
		r.pay = pay;
		r.lo = lo;
		r.hi = hi;
		pending_requests.push_back(r);
	endtask

	// mix of zero, small values, reused priorities (duplicates, range hits) and full-range values
	function automatic logic [PRIO_W-1:0] pick_priority();
		int sel;
		logic [PRIO_W-1:0] p;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			p = '0;
		else if (sel < 7)
			p = PRIO_W'($urandom_range(1, 32));
		else if (sel < 13 && recent_prios.size() > 0)
			p = PRIO_W'(recent_prios[$urandom_range(0, recent_prios.size() - 1)]);
		else
			p = PRIO_W'($urandom_range(1, 65535));
		recent_prios.push_back(p);
		if (recent_prios.size() > 32)
			void'(recent_prios.pop_front());
		return p;
	endfunction

	task automatic add_random_range();
		logic [PRIO_W-1:0] a;
		logic [PRIO_W-1:0] b;
		int sel;
		a = pick_priority();
		b = pick_priority();
		sel = $urandom_range(0, 11);
		if (sel == 0)
			add_request(OP_RNG, PRIO_W'($urandom), $urandom, '0, '1);
		else if (sel < 3)
			add_request(OP_RNG, PRIO_W'($urandom), $urandom, (a > b) ? a : b, (a > b) ? b : a);
		else
			add_request(OP_RNG, PRIO_W'($urandom), $urandom, (a < b) ? a : b, (a < b) ? b : a);
	endtask

	task automatic add_random_request();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			add_request(OP_ENQ, pick_priority(), $urandom, PRIO_W'($urandom), PRIO_W'($urandom));
		else if (sel < 75)
			add_request(OP_DEQ, PRIO_W'($urandom), $urandom, PRIO_W'($urandom), PRIO_W'($urandom));
		else if (sel < 95)
			add_random_range();
		else
			add_request(OP_CLR, PRIO_W'($urandom), $urandom, PRIO_W'($urandom), PRIO_W'($urandom));
	endtask

	task automatic report_error(string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %0h expected %0h",
				results_checked, name, got, want));
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			report_error($sformatf("result %0d arrived with no request outstanding",
				results_checked));
		end else begin
			want = expected_results.pop_front();
			compare_field("accepted", 32'(accepted), 32'(want.accepted));
			compare_field("popped_valid", 32'(popped_valid), 32'(want.popped_valid));
			compare_field("popped_payload", 32'(popped_payload), 32'(want.popped_payload));
			compare_field("removed_count", 32'(removed_count), 32'(want.removed_count));
			compare_field("entry_count", 32'(entry_count), 32'(want.entry_count));
			compare_field("queue_empty", 32'(queue_empty), 32'(want.queue_empty));
			compare_field("top_priority", 32'(top_priority), 32'(want.top_priority));
			compare_field("top_payload", 32'(top_payload), 32'(want.top_payload));
		end
		results_checked++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(apply_request(drv_req));
				requests_sent++;
			end
			if (in_valid && !in_ready) begin
				// hold request until taken
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() > TAIL_SIZE && (requests_sent / 50) % 3 != 2
					&& $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 10);
				in_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				drv_req = pending_requests.pop_front();
				operation <= drv_req.op;
				item_priority <= drv_req.prio;
				item_payload <= drv_req.pay;
				range_low <= drv_req.lo;
				range_high <= drv_req.hi;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && results_checked == 120) begin
				hold_left <= HOLD_CYCLES - 1;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (pending_requests.size() > TAIL_SIZE && (results_checked / 40) % 3 != 1
					&& $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on lack of progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int mode;
		int n;
		int k;
		idle_cycles = 0;

		// empty queue corner cases
		add_request(OP_DEQ, '0, '0, '0, '0);
		add_request(OP_RNG, '1, '1, '0, '1);
		add_request(OP_ENQ, '0, '1, '1, '1);
		// fill to capacity with extreme priorities and payloads
		add_request(OP_ENQ, '1, '1, '0, '0);
		add_request(OP_ENQ, 16'h0001, '0, '1, '0);
		add_request(OP_ENQ, 16'h8000, 32'hA5A5_A5A5, '0, '1);
		for (k = 1; k <= CAP - 3; k++)
			add_request(OP_ENQ, PRIO_W'(k * 4099), $urandom, PRIO_W'($urandom), PRIO_W'($urandom));
		add_request(OP_ENQ, 16'h0002, 32'h1234_5678, '0, '0);
		add_request(OP_RNG, '0, '0, '1, '0);
		add_request(OP_RNG, '0, '0, 16'h0001, 16'h0001);
		add_request(OP_ENQ, '1, 32'h0BAD_F00D, '0, '0);
		add_request(OP_DEQ, '0, '0, '0, '0);
		add_request(OP_CLR, '0, '0, '0, '0);

		while (pending_requests.size() < 505) begin
			mode = $urandom_range(0, 9);
			if (mode < 3) begin
				n = $urandom_range(8, 20);
				for (k = 0; k < n; k++)
					add_request(OP_ENQ, pick_priority(), $urandom,
						PRIO_W'($urandom), PRIO_W'($urandom));
			end else if (mode < 5) begin
				n = $urandom_range(3, 18);
				for (k = 0; k < n; k++)
					add_request(OP_DEQ, PRIO_W'($urandom), $urandom,
						PRIO_W'($urandom), PRIO_W'($urandom));
			end else begin
				n = $urandom_range(10, 30);
				for (k = 0; k < n; k++)
					add_random_request();
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (expected_results.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_results.size()));
		$display("covered %0d requests: %0d inserts stored, %0d refused (%0d with queue full), %0d pops",
			requests_sent, inserts_stored, inserts_refused, full_refusals, pops_done);
		$display("%0d entries dropped by range and clear, %0d results checked, %0d mismatches",
			entries_dropped, results_checked, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
